// File: sv/eira_pkg.sv
// shared constants, codes and state type of the event interval running average
// no dependencies; every other file refers to this package by scoped names
`timescale 1ns / 1ps

package eira_pkg;

   // fixed-point format and field widths
   localparam int FRAC_BITS  = 8;
   localparam int TS_W       = 32;
   localparam int AVG_W      = 40;
   localparam int MEAS_W     = 8;
   localparam int EVT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // datapath widths of the update step
   localparam int CNT_W   = MEAS_W;
   localparam int PROD_W  = CNT_W + AVG_W;
   localparam int SHIFT_W = TS_W + FRAC_BITS;
   localparam int NUM_W   = ((SHIFT_W > PROD_W) ? SHIFT_W : PROD_W) + 1;
   localparam int DEN_W   = CNT_W + 1;
   localparam int STEP_W  = $clog2(NUM_W);

   // register reset values
   localparam logic [MEAS_W-1:0] MEAS_RESET = MEAS_W'(8);
   localparam logic [EVT_W-1:0]  EVT_RESET  = EVT_W'(16);

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEASUREMENTS = 2'd0,
      CSR_EVENTS       = 2'd1
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_MAC,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// File: sv/eira_req_if.sv
// request channel: valid/ready handshake with op and timestamp
// depends on eira_pkg for field widths
`timescale 1ns / 1ps

interface eira_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [eira_pkg::TS_W-1:0]    timestamp_ms;

   modport source (output valid, output op, output timestamp_ms, input ready);
   modport sink   (input valid, input op, input timestamp_ms, output ready);
endinterface

// File: sv/eira_rsp_if.sv
// response channel: valid/ready handshake with average, valid flag and report
// depends on eira_pkg for field widths
`timescale 1ns / 1ps

interface eira_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [eira_pkg::AVG_W-1:0]   published_average;
   logic                         average_valid;
   logic                         report;

   modport source (output valid, output published_average, output average_valid,
                   output report, input ready);
   modport sink   (input valid, input published_average, input average_valid,
                   input report, output ready);
endinterface

// File: sv/eira_divider.sv
// restoring divider, one quotient bit per cycle, narrow divisor
// depends on eira_pkg for numerator and divisor widths
`timescale 1ns / 1ps

module eira_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [eira_pkg::NUM_W-1:0]    numerator,
   input  logic [eira_pkg::DEN_W-1:0]    denominator,
   output logic                          done,
   output logic [eira_pkg::NUM_W-1:0]    quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [eira_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [eira_pkg::NUM_W-1:0]    quot_ff, quot_in;
   logic [eira_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [eira_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [eira_pkg::DEN_W:0]      trial;
   logic [eira_pkg::DEN_W:0]      diff;
   logic                          fits;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, quot_ff[eira_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   // step sequencing and datapath next values
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = numerator;
         rem_in  = '0;
         den_in  = denominator;
      end else if (busy_ff) begin
         quot_in = {quot_ff[eira_pkg::NUM_W-2:0], fits};
         rem_in  = fits ? diff[eira_pkg::DEN_W-1:0] : trial[eira_pkg::DEN_W-1:0];
         step_in = step_ff + eira_pkg::STEP_W'(1);
         if (step_ff == eira_pkg::STEP_W'(eira_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: sv/event_interval_running_average.sv
// top level: sequencer, averaging state, register port and response register
// depends on eira_pkg, eira_req_if, eira_rsp_if and eira_divider
`timescale 1ns / 1ps

// Measures the time between a start mark (op 0) and each event (op 1), or
// between successive events, and keeps a cumulative moving average of those
// intervals in unsigned Q32.8 milliseconds. Every request gives one response.
// An event passes through the sequencer states COUNT, which steps the
// measurement count, MAC, the count-times-average multiply and add, DIVIDE,
// the one-bit-a-cycle divider over the 49-bit numerator, and FINISH, which
// commits and loads the response, then returns to idle, where the next
// request is accepted. A start mark goes from idle straight to FINISH.
// A finished response waits in its own register, so the next request is
// accepted while it is still unclaimed; the commit of that next request
// waits until the register is free. Register writes are expected only while
// the block is idle, and each write to a mapped register index clears the
// counters, the valid flag and the published average.
module event_interval_running_average (
   input  logic                               clock,
   input  logic                               reset,
   eira_req_if.sink                           req_ch,
   eira_rsp_if.source                         rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [eira_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eira_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   eira_pkg::state_type                state_ff, state_in;

   // configuration registers
   logic [eira_pkg::MEAS_W-1:0]        cfg_meas_ff;
   logic [eira_pkg::EVT_W-1:0]         cfg_events_ff;

   // averaging state
   logic [eira_pkg::TS_W-1:0]          prev_time_ff;
   logic [eira_pkg::AVG_W-1:0]         run_avg_ff;
   logic [eira_pkg::AVG_W-1:0]         held_avg_ff;
   logic [eira_pkg::CNT_W-1:0]         meas_count_ff;
   logic [eira_pkg::EVT_W-1:0]         event_count_ff;
   logic                               filled_ff;

   // captured request
   logic                               op_ff;
   logic [eira_pkg::TS_W-1:0]          stamp_ff;
   logic [eira_pkg::TS_W-1:0]          interval_ff;

   // response register
   logic                               rsp_valid_ff;
   logic [eira_pkg::AVG_W-1:0]         rsp_avg_ff;
   logic                               rsp_filled_ff;
   logic                               rsp_report_ff;

   // sequencer outputs
   logic                               req_ready;
   logic                               div_start;
   logic                               commit;

   logic                               req_accept;
   logic                               slot_free;
   logic                               cfg_clear;
   logic [eira_pkg::CNT_W-1:0]         window;
   logic [eira_pkg::PROD_W-1:0]        product;
   logic [eira_pkg::NUM_W-1:0]         numerator;
   logic [eira_pkg::DEN_W-1:0]         denominator;
   logic                               div_done;
   logic [eira_pkg::NUM_W-1:0]         quotient;
   logic [eira_pkg::AVG_W-1:0]         avg_sat;
   logic                               is_event;
   logic                               report_hit;
   logic [eira_pkg::AVG_W-1:0]         held_next;

   assign req_accept = req_ch.valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ch.ready;
   assign is_event   = (op_ff == eira_pkg::OP_EVENT);

   // register write decode
   always_comb begin
      cfg_clear = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            eira_pkg::CSR_MEASUREMENTS: cfg_clear = 1'b1;
            eira_pkg::CSR_EVENTS:       cfg_clear = 1'b1;
            default:                    cfg_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_meas_ff   <= eira_pkg::MEAS_RESET;
         cfg_events_ff <= eira_pkg::EVT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            eira_pkg::CSR_MEASUREMENTS:
               cfg_meas_ff <= csr_write_data[eira_pkg::MEAS_W-1:0];
            eira_pkg::CSR_EVENTS:
               cfg_events_ff <= csr_write_data[eira_pkg::EVT_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         eira_pkg::ST_IDLE:
            if (req_ch.valid) begin
               state_in = (req_ch.op == eira_pkg::OP_EVENT) ? eira_pkg::ST_COUNT
                                                            : eira_pkg::ST_FINISH;
            end
         eira_pkg::ST_COUNT:  state_in = eira_pkg::ST_MAC;
         eira_pkg::ST_MAC:    state_in = eira_pkg::ST_DIVIDE;
         eira_pkg::ST_DIVIDE: if (div_done) state_in = eira_pkg::ST_FINISH;
         eira_pkg::ST_FINISH: if (slot_free) state_in = eira_pkg::ST_IDLE;
         default:             state_in = eira_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         eira_pkg::ST_IDLE:   req_ready = 1'b1;
         eira_pkg::ST_MAC:    div_start = 1'b1;
         eira_pkg::ST_FINISH: commit    = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eira_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture, interval taken against the last recorded time
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff       <= req_ch.op;
         stamp_ff    <= req_ch.timestamp_ms;
         interval_ff <= req_ch.timestamp_ms - prev_time_ff;
      end
   end

   // effective window: measurement setting clamped to the event setting
   assign window = (eira_pkg::EVT_W'(cfg_meas_ff) < cfg_events_ff) ? cfg_meas_ff
                 : cfg_events_ff[eira_pkg::CNT_W-1:0];

   // numerator: scaled interval plus count times running average
   assign product     = meas_count_ff * run_avg_ff;
   assign numerator   = (eira_pkg::NUM_W'(interval_ff) << eira_pkg::FRAC_BITS)
                      + eira_pkg::NUM_W'(product);
   assign denominator = eira_pkg::DEN_W'(meas_count_ff) + eira_pkg::DEN_W'(1);

   eira_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (numerator),
      .denominator (denominator),
      .done        (div_done),
      .quotient    (quotient)
   );

   // saturate the new average to its field
   assign avg_sat = (|quotient[eira_pkg::NUM_W-1:eira_pkg::AVG_W]) ? '1
                  : quotient[eira_pkg::AVG_W-1:0];

   assign report_hit = is_event && (event_count_ff >= cfg_events_ff);
   assign held_next  = (is_event && filled_ff) ? avg_sat : held_avg_ff;

   // averaging state: count steps early, the rest commits with the response
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff   <= '0;
         run_avg_ff     <= '0;
         held_avg_ff    <= '0;
         meas_count_ff  <= '0;
         event_count_ff <= '0;
         filled_ff      <= 1'b0;
      end else if (cfg_clear) begin
         held_avg_ff    <= '0;
         meas_count_ff  <= '0;
         event_count_ff <= '0;
         filled_ff      <= 1'b0;
      end else begin
         if (state_ff == eira_pkg::ST_COUNT && !filled_ff) begin
            if (meas_count_ff >= window) begin
               meas_count_ff <= window;
               filled_ff     <= 1'b1;
            end else begin
               meas_count_ff <= meas_count_ff + eira_pkg::CNT_W'(1);
            end
         end
         if (commit) begin
            prev_time_ff <= stamp_ff;
            held_avg_ff  <= held_next;
            if (is_event) begin
               run_avg_ff     <= avg_sat;
               event_count_ff <= report_hit ? '0
                               : event_count_ff + eira_pkg::EVT_W'(1);
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_avg_ff    <= held_next;
         rsp_filled_ff <= filled_ff;
         rsp_report_ff <= report_hit;
      end
   end

   assign req_ch.ready             = req_ready;
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.published_average = rsp_avg_ff;
   assign rsp_ch.average_valid     = rsp_filled_ff;
   assign rsp_ch.report            = rsp_report_ff;

endmodule

// File: sv/eira_checker.sv
// port-level assertions for the event interval running average, with bind
// depends on eira_pkg and the top level event_interval_running_average
`timescale 1ns / 1ps

module eira_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [eira_pkg::AVG_W-1:0]    published_average,
   input  logic                          average_valid,
   input  logic                          report
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(published_average)
         && $stable(average_valid) && $stable(report))
      else $error("response changed while stalled");

   // no average is published before the window has filled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !average_valid |-> published_average == '0)
      else $error("average published before window filled");

   // one request at a time: busy right after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in progress");

endmodule

bind event_interval_running_average eira_checker u_eira_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .published_average (rsp_ch.published_average),
   .average_valid     (rsp_ch.average_valid),
   .report            (rsp_ch.report)
);

// File: bench/tb_top.sv
// self-checking bench for event_interval_running_average: drives marks and events,
// predicts each response in step with the design and compares them field by field
// depends on eira_pkg, eira_req_if, eira_rsp_if and the design top level
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned SETTLE_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam logic [63:0] AVG_LIMIT     = (64'd1 << eira_pkg::AVG_W) - 64'd1;

   // indexes that map to no register
   localparam logic [eira_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LOW  = 2'd2;
   localparam logic [eira_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HIGH = 2'd3;

   typedef struct packed {
      logic [eira_pkg::AVG_W-1:0] average;
      logic                       valid;
      logic                       report;
   } avg_result_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_enable;
   logic [eira_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [eira_pkg::CSR_DATA_W-1:0] csr_write_data;

   eira_req_if req_ch ();
   eira_rsp_if rsp_ch ();

   event_interval_running_average u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow of the averaging state and registers
   logic [eira_pkg::MEAS_W-1:0] window_setting = eira_pkg::MEAS_RESET;
   logic [eira_pkg::EVT_W-1:0]  period_setting = eira_pkg::EVT_RESET;
   logic [eira_pkg::TS_W-1:0]   last_mark_ms   = '0;
   logic [eira_pkg::AVG_W-1:0]  running_avg    = '0;
   logic [eira_pkg::AVG_W-1:0]  held_avg       = '0;
   logic [eira_pkg::MEAS_W-1:0] sample_count   = '0;
   logic [eira_pkg::EVT_W-1:0]  events_seen    = '0;
   logic                        window_full    = 1'b0;

   avg_result_type              pending_averages[$];
   int unsigned                 requests_sent = 0;
   int unsigned                 mismatches    = 0;
   int unsigned                 cycle_count   = 0;
   int unsigned                 req_gap_pct   = 0;
   int unsigned                 rsp_stall_pct = 0;
   logic [eira_pkg::TS_W-1:0]   mark_ms       = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fold one request into the shadow state and return the response it gives
   function automatic avg_result_type advance_average(input logic op,
                                                      input logic [eira_pkg::TS_W-1:0] now);
      logic [eira_pkg::EVT_W-1:0] window;
      logic [eira_pkg::TS_W-1:0]  interval;
      logic [63:0]                numerator;
      logic [63:0]                quotient;
      avg_result_type             result;
      result.report = 1'b0;
      if (op == eira_pkg::OP_EVENT) begin
         window = (eira_pkg::EVT_W'(window_setting) < period_setting)
                ? eira_pkg::EVT_W'(window_setting) : period_setting;
         if (!window_full) begin
            if (eira_pkg::EVT_W'(sample_count) >= window) begin
               sample_count = window[eira_pkg::MEAS_W-1:0];
               window_full  = 1'b1;
            end else begin
               sample_count = sample_count + 1'b1;
            end
         end
         interval  = now - last_mark_ms;
         numerator = (64'(interval) << eira_pkg::FRAC_BITS)
                   + 64'(sample_count) * 64'(running_avg);
         quotient  = numerator / (64'(sample_count) + 64'd1);
         if (quotient > AVG_LIMIT)
            quotient = AVG_LIMIT;
         running_avg = quotient[eira_pkg::AVG_W-1:0];
         if (window_full)
            held_avg = running_avg;
         if (events_seen >= period_setting) begin
            events_seen   = '0;
            result.report = 1'b1;
         end else begin
            events_seen = events_seen + 1'b1;
         end
      end
      last_mark_ms   = now;
      result.average = held_avg;
      result.valid   = window_full;
      return result;
   endfunction

   function automatic void apply_register_write(input logic [eira_pkg::CSR_IDX_W-1:0] index,
                                                input logic [eira_pkg::CSR_DATA_W-1:0] data);
      case (index)
         eira_pkg::CSR_MEASUREMENTS: window_setting = data[eira_pkg::MEAS_W-1:0];
         eira_pkg::CSR_EVENTS:       period_setting = data[eira_pkg::EVT_W-1:0];
         default:                    return;
      endcase
      // any real register write restarts the window and the report period
      sample_count = '0;
      events_seen  = '0;
      window_full  = 1'b0;
      held_avg     = '0;
   endfunction

   // mostly short idles, now and then a long one
   function automatic int unsigned random_idle(input int unsigned pct);
      if ($urandom_range(99) >= pct)
         return 0;
      if ($urandom_range(9) != 0)
         return $urandom_range(6, 1);
      return $urandom_range(150, 20);
   endfunction

   function automatic logic [eira_pkg::TS_W-1:0] random_interval();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 85)
         return $urandom_range(3000);
      if (pick < 95)
         return $urandom_range(1 << 20);
      return $urandom;
   endfunction

   // send one request, record its expected response, then maybe idle
   task automatic send_request(input logic op, input logic [eira_pkg::TS_W-1:0] stamp);
      int unsigned gap;
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.timestamp_ms <= stamp;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      pending_averages.push_back(advance_average(op, stamp));
      requests_sent++;
      gap = random_idle(req_gap_pct);
      if (gap != 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold off until every outstanding response has been checked
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_averages.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [eira_pkg::CSR_IDX_W-1:0] index,
                                 input logic [eira_pkg::CSR_DATA_W-1:0] data);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      apply_register_write(index, data);
   endtask

   // events with no start mark, all-ones stamps and a wrap past zero
   task automatic test_wrapped_intervals();
      send_request(eira_pkg::OP_EVENT, 32'd1000);
      send_request(eira_pkg::OP_EVENT, 32'hFFFF_FFFF);
      send_request(eira_pkg::OP_START, 32'hFFFF_FFF0);
      send_request(eira_pkg::OP_EVENT, 32'h0000_0010);
      send_request(eira_pkg::OP_START, 32'h0000_0000);
      send_request(eira_pkg::OP_EVENT, 32'h0000_0000);
      send_request(eira_pkg::OP_EVENT, 32'h5555_5555);
      send_request(eira_pkg::OP_EVENT, 32'hAAAA_AAAA);
   endtask

   // window zero, written with upper data bits set that must be dropped
   task automatic test_zero_window();
      write_register(eira_pkg::CSR_MEASUREMENTS, 16'hFF00);
      send_request(eira_pkg::OP_EVENT, 32'd500);
      send_request(eira_pkg::OP_EVENT, 32'd800);
      send_request(eira_pkg::OP_START, 32'd900);
      send_request(eira_pkg::OP_EVENT, 32'd1000);
   endtask

   // report period zero flags every event and never a start mark
   task automatic test_report_every_event();
      write_register(eira_pkg::CSR_MEASUREMENTS, 16'd5);
      write_register(eira_pkg::CSR_EVENTS, 16'd0);
      send_request(eira_pkg::OP_EVENT, 32'd1100);
      send_request(eira_pkg::OP_START, 32'd1200);
      send_request(eira_pkg::OP_EVENT, 32'd1250);
      send_request(eira_pkg::OP_EVENT, 32'd1400);
   endtask

   // writes to unmapped indexes must leave the counters running
   task automatic test_ignored_register_index();
      write_register(eira_pkg::CSR_MEASUREMENTS, 16'd4);
      write_register(eira_pkg::CSR_EVENTS, 16'd2);
      send_request(eira_pkg::OP_EVENT, 32'd1500);
      send_request(eira_pkg::OP_EVENT, 32'd1530);
      write_register(CSR_UNUSED_LOW, 16'hFFFF);
      write_register(CSR_UNUSED_HIGH, 16'h0000);
      send_request(eira_pkg::OP_EVENT, 32'd1600);
      send_request(eira_pkg::OP_EVENT, 32'd1700);
      send_request(eira_pkg::OP_EVENT, 32'd1720);
   endtask

   // largest register values, written as all-ones data
   task automatic test_largest_settings();
      write_register(eira_pkg::CSR_MEASUREMENTS, 16'hFFFF);
      write_register(eira_pkg::CSR_EVENTS, 16'hFFFF);
      send_request(eira_pkg::OP_EVENT, 32'hFFFF_FFFF);
      send_request(eira_pkg::OP_EVENT, 32'h0000_0000);
      send_request(eira_pkg::OP_EVENT, 32'h7FFF_FFFF);
   endtask

   // mostly start mark plus event bursts, some random single requests
   task automatic run_traffic_phase(input int unsigned n_items,
                                    input logic [eira_pkg::MEAS_W-1:0] window,
                                    input logic [eira_pkg::EVT_W-1:0] period,
                                    input int unsigned gap_pct,
                                    input int unsigned stall_pct);
      int unsigned first;
      int unsigned burst;
      write_register(eira_pkg::CSR_MEASUREMENTS, {8'($urandom), window});
      write_register(eira_pkg::CSR_EVENTS, period);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      first = requests_sent;
      while (requests_sent - first < n_items) begin
         if ($urandom_range(4) != 0) begin
            burst = $urandom_range(40, 1);
            if ($urandom_range(4) != 0)
               send_request(eira_pkg::OP_START, mark_ms);
            repeat (burst) begin
               mark_ms = mark_ms + random_interval();
               send_request(eira_pkg::OP_EVENT, mark_ms);
            end
         end else begin
            send_request(1'($urandom), $urandom);
         end
         if ($urandom_range(39) == 0)
            drain_results();
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(280, 8'd8, 16'd16, 30, 3);
      run_traffic_phase(400, 8'd255, 16'hFFFF, 10, 2);
      run_traffic_phase(280, 8'd255, 16'd40, 0, 0);
      run_traffic_phase(280, 8'd0, 16'd0, 40, 5);
      run_traffic_phase(280, 8'd1, 16'd2, 20, 3);
      run_traffic_phase(280, 8'($urandom), 16'($urandom_range(300)), 25, 3);
   endtask

   // response side back-pressure
   initial begin
      int unsigned stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0)
            stall_left = random_idle(rsp_stall_pct);
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      avg_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_averages.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = pending_averages.pop_front();
            if (rsp_ch.published_average !== want.average) begin
               $error("published_average: expected %h, got %h", want.average,
                      rsp_ch.published_average);
               mismatches++;
            end
            if (rsp_ch.average_valid !== want.valid) begin
               $error("average_valid: expected %b, got %b", want.valid, rsp_ch.average_valid);
               mismatches++;
            end
            if (rsp_ch.report !== want.report) begin
               $error("report: expected %b, got %b", want.report, rsp_ch.report);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.op           = eira_pkg::OP_START;
      req_ch.timestamp_ms = '0;
      csr_write_enable    = 1'b0;
      csr_index           = eira_pkg::CSR_MEASUREMENTS;
      csr_write_data      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_gap_pct   = 20;
      rsp_stall_pct = 2;
      test_wrapped_intervals();
      test_zero_window();
      test_report_every_event();
      test_ignored_register_index();
      test_largest_settings();
      test_random_traffic();

      drain_results();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
